// File: hw/rtl/fr_pkg.sv
// ----------------------------------------------------------------------------
// fr_pkg: shared constants and types for the Fresnel reflectance pipeline
// Fixed-point formats, working widths, register indexes and the control
// record that travels with every item down the pipeline.
// ----------------------------------------------------------------------------
package fr_pkg;

  localparam int FRAC_BITS = 16;               // Q1.FRAC_BITS cosine and result
  localparam int WORK_BITS = 30;               // Q2.30 internal values
  localparam int IDX_FRAC  = 12;               // Q4.12 refractive index
  localparam int IDX_W     = 16;
  localparam int IN_W      = FRAC_BITS + 2;
  localparam int OUT_W     = FRAC_BITS + 1;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  // working widths
  localparam int RT_W  = WORK_BITS + 1;        // square root result
  localparam int SQ_W  = 2 * WORK_BITS + 2;    // square root remainder
  localparam int QT_W  = WORK_BITS;            // quotient below 1.0
  localparam int DV_W  = WORK_BITS + IDX_W;    // sin r divider remainder
  localparam int NS_W  = IDX_W + 1;            // n + 1
  localparam int ND_W  = 2 * NS_W;             // (n + 1)^2
  localparam int NR_W  = ND_W + OUT_W;         // normal-limit divider remainder
  localparam int PR_W  = 2 * RT_W;             // angle product
  localparam int PW    = WORK_BITS + 2;        // sin/cos of sum and difference
  localparam int P2_W  = WORK_BITS + 3;        // their squares
  localparam int RD_W  = WORK_BITS + P2_W;     // ratio divider remainder
  localparam int HP_W  = RT_W + PW;            // final product

  localparam logic [RT_W-1:0]  ONE_W   = RT_W'(1) << WORK_BITS;
  localparam logic [SQ_W-1:0]  ONE_SQ  = SQ_W'(1) << (2 * WORK_BITS);
  localparam logic [OUT_W-1:0] ONE_OUT = OUT_W'(1) << FRAC_BITS;
  localparam logic [IDX_W-1:0] IDX_ONE = IDX_W'(1) << IDX_FRAC;
  localparam logic [IDX_W-1:0] INDEX_RESET = IDX_W'(5448);

  // register indexes (paddr[2])
  localparam logic REG_ENABLE = 1'b0;
  localparam logic REG_INDEX  = 1'b1;

  typedef struct packed {
    logic             vld;
    logic             zero;   // disabled or negative cosine
    logic             nl;     // normal-incidence limit
    logic             tir;    // total internal reflection
    logic [OUT_W-1:0] nlq;    // normal-incidence limit value
  } ctl_t;

endpackage

// File: hw/rtl/fresnel_reflectance.sv
// ----------------------------------------------------------------------------
// fresnel_reflectance: unpolarized Fresnel reflectance pipeline
// Cosine of incidence in, reflectance out, both Q1.16; one item per cycle unless the output stalls.
// ----------------------------------------------------------------------------
//
//  channel   | valid            | stall            | payload
//  ----------+------------------+------------------+----------------------
//  input     | in_valid_i       | in_stall_o       | cos_incidence_i
//  output    | out_valid_o      | out_stall_i      | reflectance_o
//  config    | psel & penable   | pready (always 1)| paddr, pwdata, prdata
//
//  One item enters every cycle unless the output stalls; depth is set by the
//  bit-per-stage units: two 31-step square roots and two 30-step dividers.
//  Reset clears the valid bits and loads the register reset values.
//  A stalled output holds the whole pipeline in place; input stalls then.
//
module fresnel_reflectance (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fr_pkg::ADDR_W-1:0]           paddr,
  input  logic [fr_pkg::DATA_W-1:0]           pwdata,
  output logic [fr_pkg::DATA_W-1:0]           prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [fr_pkg::IN_W-1:0]      cos_incidence_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [fr_pkg::OUT_W-1:0]            reflectance_o
);
  import fr_pkg::*;

  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [RT_W-1:0] root;
  } sq_t;

  // sqrt of incidence plus normal-limit division
  typedef struct packed {
    ctl_t            ctl;
    logic [QT_W-1:0] c;
    logic [IDX_W-1:0] n;
    sq_t             sq;
    logic [NR_W-1:0] nrem;
    logic [ND_W-1:0] nden;
  } a_t;

  // sin r division
  typedef struct packed {
    ctl_t             ctl;
    logic [QT_W-1:0]  c;
    logic [RT_W-1:0]  s;
    logic [IDX_W-1:0] n;
    logic [DV_W-1:0]  rem;
    logic [QT_W-1:0]  q;
  } b_t;

  // sqrt of refraction
  typedef struct packed {
    ctl_t            ctl;
    logic [QT_W-1:0] c;
    logic [RT_W-1:0] s;
    logic [QT_W-1:0] sr;
    sq_t             sq;
  } c_t;

  typedef struct packed {
    ctl_t            ctl;
    logic [PR_W-1:0] a1, b1, a2, b2;
  } d_t;

  typedef struct packed {
    ctl_t          ctl;
    logic [PW-1:0] sm, sp, cp, cm;
  } e_t;

  typedef struct packed {
    ctl_t            ctl;
    logic [P2_W-1:0] sm2, sp2, cp2, cm2;
  } f_t;

  // ratio division, both ratios side by side
  typedef struct packed {
    ctl_t            ctl;
    logic            rs_full;
    logic            t_full;
    logic [P2_W-1:0] sd, td;
    logic [RD_W-1:0] srem, trem;
    logic [QT_W-1:0] sq, tq;
  } g_t;

  typedef struct packed {
    ctl_t            ctl;
    logic [HP_W-1:0] prod;
  } h_t;

  function automatic sq_t sqrt_step(sq_t x, int j);
    sq_t             y;
    logic [SQ_W-1:0] trial;
    trial = (SQ_W'(x.root) << (j + 1)) + (SQ_W'(1) << (2 * j));
    y = x;
    if (x.rem >= trial) begin
      y.rem  = x.rem - trial;
      y.root = x.root | (RT_W'(1) << j);
    end
    return y;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic             refraction_enable_q;
  logic [IDX_W-1:0] refractive_index_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refraction_enable_q <= 1'b0;
      refractive_index_q  <= INDEX_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_ENABLE: refraction_enable_q <= pwdata[0];
        REG_INDEX:  refractive_index_q  <= pwdata[IDX_W-1:0];
        default:    refraction_enable_q <= refraction_enable_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ENABLE: prdata = DATA_W'(refraction_enable_q);
      REG_INDEX:  prdata = DATA_W'(refractive_index_q);
      default:    prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Flow control: every stage advances unless the result waits at the output
  // --------------------------------------------------------------------------
  logic             out_vld_q;
  logic [OUT_W-1:0] refl_q;
  logic             adv;

  assign adv        = ~(out_vld_q & out_stall_i);
  assign in_stall_o = ~adv;

  // --------------------------------------------------------------------------
  // Entry: classify the cosine, form 1 - c^2 and the normal-limit operands
  // --------------------------------------------------------------------------
  a_t s0_d, s0_q;

  always_comb begin
    logic [FRAC_BITS-1:0]   craw;
    logic [2*FRAC_BITS-1:0] csq;
    logic [IDX_W-1:0]       d;
    logic [NS_W-1:0]        ssum;
    logic [2*IDX_W-1:0]     dd;
    craw = cos_incidence_i[FRAC_BITS-1:0];
    csq  = craw * craw;
    d    = (refractive_index_q > IDX_ONE) ? refractive_index_q - IDX_ONE
                                          : IDX_ONE - refractive_index_q;
    ssum = NS_W'(refractive_index_q) + NS_W'(IDX_ONE);
    dd   = d * d;
    s0_d          = '0;
    s0_d.ctl.vld  = in_valid_i;
    s0_d.ctl.zero = ~refraction_enable_q | cos_incidence_i[IN_W-1];
    s0_d.ctl.nl   = cos_incidence_i[IN_W-2];
    s0_d.c        = QT_W'(craw) << (WORK_BITS - FRAC_BITS);
    s0_d.n        = refractive_index_q;
    s0_d.sq.rem   = ONE_SQ - (SQ_W'(csq) << (2 * (WORK_BITS - FRAC_BITS)));
    s0_d.sq.root  = '0;
    s0_d.nden     = ssum * ssum;
    s0_d.nrem     = (NR_W'(dd) << FRAC_BITS) + NR_W'(s0_d.nden >> 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s0_q.ctl.vld <= 1'b0;
    else if (adv) s0_q <= s0_d;
  end

  // --------------------------------------------------------------------------
  // sin i = sqrt(1 - c^2), one root bit a stage; the normal limit
  // ((n-1)/(n+1))^2 divides alongside in the first stages
  // --------------------------------------------------------------------------
  a_t a_q [RT_W];

  for (genvar k = 0; k < RT_W; k++) begin : g_sqa
    a_t prev, nxt;
    if (k == 0) begin : g_first
      assign prev = s0_q;
    end else begin : g_next
      assign prev = a_q[k-1];
    end
    always_comb begin
      logic [NR_W-1:0] dsh;
      nxt    = prev;
      nxt.sq = sqrt_step(prev.sq, RT_W - 1 - k);
      dsh    = NR_W'(prev.nden) << (OUT_W - 1 - k);
      if (k < OUT_W && prev.nrem >= dsh) begin
        nxt.nrem    = prev.nrem - dsh;
        nxt.ctl.nlq = prev.ctl.nlq | (OUT_W'(1) << (OUT_W - 1 - k));
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) a_q[k].ctl.vld <= 1'b0;
      else if (adv) a_q[k] <= nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Total internal reflection test, then sin r = sin i / n
  // --------------------------------------------------------------------------
  b_t b0_d, b0_q;

  always_comb begin
    b0_d         = '0;
    b0_d.ctl     = a_q[RT_W-1].ctl;
    b0_d.c       = a_q[RT_W-1].c;
    b0_d.n       = a_q[RT_W-1].n;
    b0_d.s       = a_q[RT_W-1].sq.root;
    b0_d.rem     = DV_W'(b0_d.s) << IDX_FRAC;
    b0_d.ctl.tir = b0_d.rem >= (DV_W'(b0_d.n) << WORK_BITS);
    b0_d.q       = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b0_q.ctl.vld <= 1'b0;
    else if (adv) b0_q <= b0_d;
  end

  b_t b_q [QT_W];

  for (genvar k = 0; k < QT_W; k++) begin : g_dvb
    b_t prev, nxt;
    if (k == 0) begin : g_first
      assign prev = b0_q;
    end else begin : g_next
      assign prev = b_q[k-1];
    end
    always_comb begin
      logic [DV_W-1:0] dsh;
      nxt = prev;
      dsh = DV_W'(prev.n) << (QT_W - 1 - k);
      if (prev.rem >= dsh) begin
        nxt.rem = prev.rem - dsh;
        nxt.q   = prev.q | (QT_W'(1) << (QT_W - 1 - k));
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) b_q[k].ctl.vld <= 1'b0;
      else if (adv) b_q[k] <= nxt;
    end
  end

  // --------------------------------------------------------------------------
  // cos r = sqrt(1 - sin^2 r)
  // --------------------------------------------------------------------------
  c_t m1_d, m1_q;

  always_comb begin
    logic [2*QT_W-1:0] srsq;
    srsq         = b_q[QT_W-1].q * b_q[QT_W-1].q;
    m1_d.ctl     = b_q[QT_W-1].ctl;
    m1_d.c       = b_q[QT_W-1].c;
    m1_d.s       = b_q[QT_W-1].s;
    m1_d.sr      = b_q[QT_W-1].q;
    m1_d.sq.rem  = ONE_SQ - SQ_W'(srsq);
    m1_d.sq.root = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m1_q.ctl.vld <= 1'b0;
    else if (adv) m1_q <= m1_d;
  end

  c_t c_q [RT_W];

  for (genvar k = 0; k < RT_W; k++) begin : g_sqc
    c_t prev, nxt;
    if (k == 0) begin : g_first
      assign prev = m1_q;
    end else begin : g_next
      assign prev = c_q[k-1];
    end
    always_comb begin
      nxt    = prev;
      nxt.sq = sqrt_step(prev.sq, RT_W - 1 - k);
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) c_q[k].ctl.vld <= 1'b0;
      else if (adv) c_q[k] <= nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Angle addition: products, then sin/cos of (i-r) and (i+r), then squares
  // --------------------------------------------------------------------------
  d_t m2_d, m2_q;
  e_t e_d, e_q;
  f_t f_d, f_q;

  always_comb begin
    logic [RT_W-1:0] cr, cc, srr;
    cr      = c_q[RT_W-1].sq.root;
    cc      = RT_W'(c_q[RT_W-1].c);
    srr     = RT_W'(c_q[RT_W-1].sr);
    m2_d.ctl = c_q[RT_W-1].ctl;
    m2_d.a1  = c_q[RT_W-1].s * cr;
    m2_d.b1  = cc * srr;
    m2_d.a2  = cc * cr;
    m2_d.b2  = c_q[RT_W-1].s * srr;
  end

  always_comb begin
    logic [PR_W-1:0] d1, d2;
    logic [PR_W:0]   s1, s2;
    d1 = (m2_q.a1 > m2_q.b1) ? m2_q.a1 - m2_q.b1 : m2_q.b1 - m2_q.a1;
    d2 = (m2_q.a2 > m2_q.b2) ? m2_q.a2 - m2_q.b2 : m2_q.b2 - m2_q.a2;
    s1 = {1'b0, m2_q.a1} + {1'b0, m2_q.b1};
    s2 = {1'b0, m2_q.a2} + {1'b0, m2_q.b2};
    e_d.ctl = m2_q.ctl;
    e_d.sm  = d1[WORK_BITS+PW-1:WORK_BITS];
    e_d.sp  = s1[WORK_BITS+PW-1:WORK_BITS];
    e_d.cp  = d2[WORK_BITS+PW-1:WORK_BITS];
    e_d.cm  = s2[WORK_BITS+PW-1:WORK_BITS];
  end

  always_comb begin
    logic [2*PW-1:0] p0, p1, p2, p3;
    p0 = e_q.sm * e_q.sm;
    p1 = e_q.sp * e_q.sp;
    p2 = e_q.cp * e_q.cp;
    p3 = e_q.cm * e_q.cm;
    f_d.ctl = e_q.ctl;
    f_d.sm2 = p0[WORK_BITS+P2_W-1:WORK_BITS];
    f_d.sp2 = p1[WORK_BITS+P2_W-1:WORK_BITS];
    f_d.cp2 = p2[WORK_BITS+P2_W-1:WORK_BITS];
    f_d.cm2 = p3[WORK_BITS+P2_W-1:WORK_BITS];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_q.ctl.vld <= 1'b0;
      e_q.ctl.vld  <= 1'b0;
      f_q.ctl.vld  <= 1'b0;
    end else if (adv) begin
      m2_q <= m2_d;
      e_q  <= e_d;
      f_q  <= f_d;
    end
  end

  // --------------------------------------------------------------------------
  // Rs = sm2/sp2 and T = cp2/cm2; a ratio at or above 1.0 saturates, so the
  // dividers only produce the fraction
  // --------------------------------------------------------------------------
  g_t g0_d, g0_q;

  always_comb begin
    g0_d         = '0;
    g0_d.ctl     = f_q.ctl;
    // vanishing sin^2(i+r) falls back to the normal limit
    g0_d.ctl.nl  = f_q.ctl.nl | ((f_q.sp2 == '0) & ~f_q.ctl.tir);
    g0_d.rs_full = f_q.sm2 >= f_q.sp2;
    g0_d.t_full  = (f_q.cm2 == '0) | (f_q.cp2 >= f_q.cm2);
    g0_d.sd      = f_q.sp2;
    g0_d.td      = f_q.cm2;
    g0_d.srem    = RD_W'(f_q.sm2) << WORK_BITS;
    g0_d.trem    = RD_W'(f_q.cp2) << WORK_BITS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) g0_q.ctl.vld <= 1'b0;
    else if (adv) g0_q <= g0_d;
  end

  g_t g_q [QT_W];

  for (genvar k = 0; k < QT_W; k++) begin : g_dvg
    g_t prev, nxt;
    if (k == 0) begin : g_first
      assign prev = g0_q;
    end else begin : g_next
      assign prev = g_q[k-1];
    end
    always_comb begin
      logic [RD_W-1:0] ssh, tsh;
      nxt = prev;
      ssh = RD_W'(prev.sd) << (QT_W - 1 - k);
      tsh = RD_W'(prev.td) << (QT_W - 1 - k);
      if (prev.srem >= ssh) begin
        nxt.srem = prev.srem - ssh;
        nxt.sq   = prev.sq | (QT_W'(1) << (QT_W - 1 - k));
      end
      if (prev.trem >= tsh) begin
        nxt.trem = prev.trem - tsh;
        nxt.tq   = prev.tq | (QT_W'(1) << (QT_W - 1 - k));
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) g_q[k].ctl.vld <= 1'b0;
      else if (adv) g_q[k] <= nxt;
    end
  end

  // --------------------------------------------------------------------------
  // R = Rs * (1 + T) / 2, round to the output format, pick the special cases
  // --------------------------------------------------------------------------
  h_t h_d, h_q;

  always_comb begin
    logic [RT_W-1:0] rs, t;
    logic [PW-1:0]   tt;
    rs = g_q[QT_W-1].rs_full ? ONE_W : RT_W'(g_q[QT_W-1].sq);
    t  = g_q[QT_W-1].t_full  ? ONE_W : RT_W'(g_q[QT_W-1].tq);
    tt = PW'(ONE_W) + PW'(t);
    h_d.ctl  = g_q[QT_W-1].ctl;
    h_d.prod = rs * tt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) h_q.ctl.vld <= 1'b0;
    else if (adv) h_q <= h_d;
  end

  logic [OUT_W-1:0] refl_d;

  always_comb begin
    logic [PW-1:0]   r;
    logic [PW:0]     rr;
    logic [PW:0]     sh;
    r  = h_q.prod[WORK_BITS+PW:WORK_BITS+1];
    rr = {1'b0, r} + ((PW+1)'(1) << (WORK_BITS - FRAC_BITS - 1));
    sh = rr >> (WORK_BITS - FRAC_BITS);
    if (h_q.ctl.zero) begin
      refl_d = '0;
    end else if (h_q.ctl.nl & ~h_q.ctl.tir) begin
      refl_d = h_q.ctl.nlq;
    end else if (h_q.ctl.tir & ~h_q.ctl.nl) begin
      refl_d = ONE_OUT;
    end else if (h_q.ctl.nl) begin
      // cosine at 1.0 wins over the reflection test
      refl_d = h_q.ctl.nlq;
    end else if (sh > (PW+1)'(ONE_OUT)) begin
      refl_d = ONE_OUT;
    end else begin
      refl_d = sh[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= h_q.ctl.vld;
      refl_q    <= refl_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign reflectance_o = refl_q;

`ifndef SYNTHESIS
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> reflectance_o <= ONE_OUT)
    else $error("reflectance above 1.0");

  a_disabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !refraction_enable_q) |-> reflectance_o == '0)
    else $error("nonzero reflectance with refraction disabled");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (h_q.ctl.vld && !adv) |=> h_q.ctl.vld)
    else $error("pipeline item lost during stall");
`endif

endmodule

// File: dv/fresnel_reflectance_tb.sv
// ----------------------------------------------------------------------------
// fresnel_reflectance_tb: self-checking bench for the Fresnel reflectance pipe
// Drives cosine items through the valid/stall input with random gaps. Predicts
// each reflectance in fixed point from the current register settings and
// compares it, in order, with what leaves the output channel. Registers are
// set over the APB port between phases, while the pipeline is empty.
// ----------------------------------------------------------------------------
module fresnel_reflectance_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fr_pkg::*;

  localparam int PIPE_DEPTH = 131;     // depth of the block's register chain
  localparam int DRAIN_WAIT = PIPE_DEPTH + 20;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [ADDR_W-1:0]       paddr = '0;
  logic [DATA_W-1:0]       pwdata = '0;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic signed [IN_W-1:0]  cos_incidence_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [OUT_W-1:0]        reflectance_o;

  fresnel_reflectance DUT (.*);

  always #5 clk_i = ~clk_i;

  // Bench copy of the registers, updated together with each APB write.
  logic             refract_on = 1'b0;
  logic [IDX_W-1:0] index_n = INDEX_RESET;

  logic [IN_W-1:0]  pending_cos[$];
  logic [OUT_W-1:0] expected_refl[$];
  int               mismatches = 0;
  bit               gaps_on = 1'b1;
  bit               hold_req = 1'b0;

  // Integer square root, bit by bit.
  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // ((n-1)/(n+1))^2, rounded half up, in Q1.16.
  function automatic logic [63:0] normal_incidence(logic [63:0] n);
    logic [63:0] unit_n, d, s, num, den, q;
    unit_n = 64'd1 << IDX_FRAC;
    d = (n > unit_n) ? n - unit_n : unit_n - n;
    s = n + unit_n;
    num = d * d * (64'd1 << FRAC_BITS);
    den = s * s;
    q = (num + den / 2) / den;
    return (q > (64'd1 << FRAC_BITS)) ? (64'd1 << FRAC_BITS) : q;
  endfunction

  function automatic logic [63:0] adiff(logic [63:0] a, logic [63:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [OUT_W-1:0] predict_reflectance(logic [IN_W-1:0] raw,
                                                           logic en,
                                                           logic [IDX_W-1:0] idx);
    logic [63:0] one, n, c, s, sr, cr, a, b, sm, sp, cp, cm;
    logic [63:0] sm2, sp2, cp2, cm2, rs, t, r, res;
    one = 64'd1 << WORK_BITS;
    n = 64'(idx);
    if (!en) return '0;
    if (raw[IN_W-1]) return '0;                     // negative cosine
    if (64'(raw) >= (64'd1 << FRAC_BITS)) return OUT_W'(normal_incidence(n));
    c = 64'(raw) << (WORK_BITS - FRAC_BITS);
    s = isqrt(one * one - c * c);
    if ((s << IDX_FRAC) >= (n << WORK_BITS)) return ONE_OUT;  // total internal refl.
    sr = (s << IDX_FRAC) / n;
    cr = isqrt(one * one - sr * sr);
    a = s * cr;
    b = c * sr;
    sm = adiff(a, b) >> WORK_BITS;
    sp = (a + b) >> WORK_BITS;
    a = c * cr;
    b = s * sr;
    cp = adiff(a, b) >> WORK_BITS;
    cm = (a + b) >> WORK_BITS;
    sm2 = (sm * sm) >> WORK_BITS;
    sp2 = (sp * sp) >> WORK_BITS;
    cp2 = (cp * cp) >> WORK_BITS;
    cm2 = (cm * cm) >> WORK_BITS;
    if (sp2 == 0) return OUT_W'(normal_incidence(n));  // sum angle vanishes
    rs = (sm2 << WORK_BITS) / sp2;
    if (rs > one) rs = one;
    if (cm2 == 0) begin
      t = one;
    end else begin
      t = (cp2 << WORK_BITS) / cm2;
      if (t > one) t = one;
    end
    r = (rs * (one + t)) >> (WORK_BITS + 1);
    res = (r + (64'd1 << (WORK_BITS - FRAC_BITS - 1))) >> (WORK_BITS - FRAC_BITS);
    return (res > 64'(ONE_OUT)) ? ONE_OUT : OUT_W'(res);
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int draw_gap();
    int p;
    p = $urandom_range(0, 99);
    if (!gaps_on || p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Driver: record accepted items, then present the next one.
  int send_gap = 0;
  always @(posedge clk_i) begin
    logic next_valid;
    next_valid = in_valid_i;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_refl.push_back(predict_reflectance(cos_incidence_i, refract_on, index_n));
        next_valid = 1'b0;
        send_gap = draw_gap();
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_cos.size() > 0) begin
          cos_incidence_i <= pending_cos.pop_front();
          next_valid = 1'b1;
        end
      end
    end
    in_valid_i <= next_valid;
  end

  // Receiver stall: random gaps, plus one long hold to fill the pipeline.
  int hold_cnt = 0;
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= (draw_gap() > 0);
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    logic [OUT_W-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_refl.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected reflectance %0d", reflectance_o);
      end else begin
        want = expected_refl.pop_front();
        if (reflectance_o !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: reflectance expected %0d got %0d", want, reflectance_o);
        end
      end
    end
  end

  task automatic apb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Hold until every queued item has gone through and the pipe is empty.
  task automatic drain();
    while (pending_cos.size() > 0 || in_valid_i || expected_refl.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic set_regs(logic en, logic [IDX_W-1:0] idx);
    drain();
    apb_write(ADDR_W'(4 * REG_ENABLE), DATA_W'(en));
    apb_write(ADDR_W'(4 * REG_INDEX), DATA_W'(idx));
    refract_on = en;
    index_n = idx;
  endtask

  // Random cosines: mostly legal Q1.16, some raw 18-bit patterns.
  task automatic add_random(int count);
    repeat (count) begin
      if ($urandom_range(0, 9) < 7)
        pending_cos.push_back(IN_W'($urandom_range(0, 65536)));
      else if ($urandom_range(0, 1))
        pending_cos.push_back(IN_W'(-$urandom_range(0, 65536)));
      else
        pending_cos.push_back(IN_W'($urandom));
    end
  endtask

  task automatic add_directed();
    logic [IN_W-1:0] pts[$];
    pts = '{18'd0, 18'd1, 18'd256, 18'd32768, 18'd46341, 18'd65000, 18'd65534,
            18'd65535, 18'd65536, 18'd65537, 18'h1FFFF, 18'h20000, 18'h3FFFF,
            18'h30000, 18'h2AAAA, 18'h15555};
    foreach (pts[k]) pending_cos.push_back(pts[k]);
  endtask

  initial begin
    int phase;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset values first: refraction off gives zero everywhere.
    add_directed();
    set_regs(1'b1, INDEX_RESET);
    add_directed();
    add_random(60);

    // Fill the pipe while the receiver holds off.
    @(posedge clk_i);
    hold_req = 1'b1;
    add_random(140);
    drain();

    // Sweep index settings, extremes included.
    set_regs(1'b1, IDX_W'(1));
    add_directed();
    add_random(40);
    set_regs(1'b1, 16'hFFFF);
    add_directed();
    add_random(40);
    set_regs(1'b1, IDX_ONE);
    add_directed();
    add_random(40);
    set_regs(1'b1, IDX_W'(2048));
    add_directed();
    add_random(40);
    set_regs(1'b0, IDX_W'(6144));
    add_random(30);

    for (phase = 0; phase < 6; phase++) begin
      set_regs(1'b1, IDX_W'($urandom_range(1, 65535)));
      gaps_on = (phase % 3 != 2);
      add_random(60);
    end
    gaps_on = 1'b1;
    set_regs(1'b1, INDEX_RESET);
    add_random(60);

    drain();
    if (mismatches == 0 && expected_refl.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
